>>> hdl/ppa_pkg.sv
// shared widths, codes and defaults for the process page allocator
package ppa_pkg;

    // payload field widths
    localparam int REQ_W      = 3;
    localparam int PID_W      = 32;
    localparam int OFF_W      = 16;
    localparam int DATA_W     = 32;
    localparam int BUCKET_W   = 4;

    // configuration register widths and reset values
    localparam int PSIZE_W    = 11;
    localparam int PCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [PSIZE_W-1:0]  PSIZE_RESET  = 11'd64;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

    // default sizes
    localparam int DEF_MAX_PAGES = 16;
    localparam int DEF_MEM_WORDS = 1024;

endpackage

>>> hdl/ppa_cfg_if.sv
// configuration write channel of the process page allocator
interface ppa_cfg_if;
    import ppa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/ppa_req_if.sv
// request channel of the process page allocator
interface ppa_req_if;
    import ppa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [PID_W-1:0]         pid;
    logic signed [OFF_W-1:0]  offset;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output req_type, output pid, output offset,
                    output data_in, input ready);
    modport sink   (input valid, input req_type, input pid, input offset,
                    input data_in, output ready);
endinterface

>>> hdl/ppa_rsp_if.sv
// response channel of the process page allocator
interface ppa_rsp_if;
    import ppa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [BUCKET_W-1:0]      bucket;
    logic signed [DATA_W-1:0] read_data;

    modport source (output valid, output ok, output bucket, output read_data,
                    input ready);
    modport sink   (input valid, input ok, input bucket, input read_data,
                    output ready);
endinterface

>>> hdl/process_page_allocator_unit.sv
// Process page allocator: one page per process id and a shared word memory.
// Channels: cfg writes the page length in words (index 0) or page_count
// (index 1) and is always ready; writes are expected only while no request
// is in flight. req carries one request (insert, search, write, read,
// delete); it is ready only while the block is idle, one request at a time.
// rsp carries exactly one result per request and holds it until taken; a
// stalled receiver keeps the block busy with no loss.
// Sequence from the req transfer: the owner table is scanned one entry a cycle,
// then a decide step ends insert, delete and failed write or read requests
// and presents their result; write adds a memory step and read a memory
// step and a read-wait step. Search adds a bit-serial pid mod page_count
// (the clamped effective count) on the subtract unit. After each result
// transfer the block returns to idle, and only there takes the next request.
// The word address page * page length + offset wraps by masking, so
// MEM_WORDS must be a power of two.
// Reset: page table empty, page length 64, page_count 16, then a clearing
// pass zeroes the word memory with req not ready.
module process_page_allocator_unit #(
    parameter int MAX_PAGES = ppa_pkg::DEF_MAX_PAGES,
    parameter int MEM_WORDS = ppa_pkg::DEF_MEM_WORDS
) (
    input  logic       clk,
    input  logic       rst_n,
    ppa_cfg_if.sink    cfg,
    ppa_req_if.sink    req,
    ppa_rsp_if.source  rsp
);
    import ppa_pkg::*;

    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int CW     = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;
    localparam int SUM_W  = PAGE_W + PSIZE_W + 1;
    localparam int DIV_W  = (SUM_W > PID_W) ? SUM_W : PID_W;
    localparam int R_W    = ((CNT_W > BUCKET_W) ? CNT_W : BUCKET_W) + 1;
    localparam int STEP_W = $clog2(DIV_W + 1);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_DECIDE = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_MEM    = 8'b0010_0000,
        ST_RDWAIT = 8'b0100_0000,
        ST_RESP   = 8'b1000_0000
    } state_t;

    // control registers
    state_t                 state_reg, state_next;
    logic [MAX_PAGES-1:0]   page_used_reg, page_used_next;
    logic [PSIZE_W-1:0]     page_len_reg;
    logic [PCOUNT_W-1:0]    page_count_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [PAGE_W:0]        scan_cnt_reg, scan_cnt_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   found_reg, found_next;
    logic                   free_found_reg, free_found_next;
    logic [STEP_W-1:0]      div_cnt_reg, div_cnt_next;

    // payload registers
    logic [REQ_W-1:0]       req_type_reg, req_type_next;
    logic [PID_W-1:0]       pid_reg, pid_next;
    logic [OFF_W-1:0]       offset_reg, offset_next;
    logic [DATA_W-1:0]      data_reg, data_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PAGE_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [PAGE_W-1:0]      found_idx_reg, found_idx_next;
    logic [PAGE_W-1:0]      free_idx_reg, free_idx_next;
    logic [R_W-1:0]         div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]       div_dvd_reg, div_dvd_next;
    logic [R_W-1:0]         div_dsr_reg, div_dsr_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic                   ok_reg, ok_next;
    logic [BUCKET_W-1:0]    bucket_reg, bucket_next;
    logic [DATA_W-1:0]      rdata_reg, rdata_next;

    // combinational helpers
    logic [CW-1:0]          pc_ext;
    logic [CW-1:0]          eff_wide;
    logic [CNT_W-1:0]       eff_cnt;
    logic                   scan_issue;
    logic                   off_ok;
    logic [SUM_W-1:0]       mul_sum;
    logic [R_W-1:0]         div_shift;
    logic [R_W-1:0]         div_rem_new;

    // memory ports
    logic                   owner_we;
    logic [PID_W-1:0]       owner_rdata;
    logic                   word_we;
    logic [ADDR_W-1:0]      word_waddr;
    logic [DATA_W-1:0]      word_wdata;
    logic [DATA_W-1:0]      word_rdata;

    // owner table, one pid per page
    ppa_ram #(
        .WIDTH (PID_W),
        .DEPTH (MAX_PAGES)
    ) u_owner_ram (
        .clk   (clk),
        .we    (owner_we),
        .waddr (free_idx_reg),
        .wdata (pid_reg),
        .raddr (scan_cnt_reg[PAGE_W-1:0]),
        .rdata (owner_rdata)
    );

    // shared word memory
    ppa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .raddr (addr_reg),
        .rdata (word_rdata)
    );

    // effective page count, clamped to 1..MAX_PAGES
    always_comb
    begin
        pc_ext = CW'(page_count_reg);
        priority if (pc_ext == '0)
        begin
            eff_wide = CW'(1);
        end
        else if (pc_ext > CW'(MAX_PAGES))
        begin
            eff_wide = CW'(MAX_PAGES);
        end
        else
        begin
            eff_wide = pc_ext;
        end
        eff_cnt = eff_wide[CNT_W-1:0];
    end

    // offset check and page address sum, wrapped later by masking
    assign off_ok  = !offset_reg[OFF_W-1] &&
                     (offset_reg[OFF_W-2:0] < (OFF_W-1)'(page_len_reg));
    assign mul_sum = SUM_W'(found_idx_reg) * SUM_W'(page_len_reg) +
                     SUM_W'(offset_reg[PSIZE_W-1:0]);

    // restoring remainder step for the search divider
    assign div_shift   = {div_rem_reg[R_W-2:0], div_dvd_reg[DIV_W-1]};
    assign div_rem_new = (div_shift >= div_dsr_reg) ? (div_shift - div_dsr_reg) : div_shift;

    assign scan_issue = (scan_cnt_reg < (PAGE_W+1)'(MAX_PAGES));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        page_used_next  = page_used_reg;
        clr_cnt_next    = clr_cnt_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        div_cnt_next    = div_cnt_reg;
        req_type_next   = req_type_reg;
        pid_next        = pid_reg;
        offset_next     = offset_reg;
        data_next       = data_reg;
        cnt_next        = cnt_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_idx_next  = found_idx_reg;
        free_idx_next   = free_idx_reg;
        div_rem_next    = div_rem_reg;
        div_dvd_next    = div_dvd_reg;
        div_dsr_next    = div_dsr_reg;
        addr_next       = addr_reg;
        ok_next         = ok_reg;
        bucket_next     = bucket_reg;
        rdata_next      = rdata_reg;
        owner_we        = 1'b0;
        word_we         = 1'b0;
        word_waddr      = addr_reg;
        word_wdata      = data_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                word_we      = 1'b1;
                word_waddr   = clr_cnt_reg;
                word_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next   = req.req_type;
                    pid_next        = req.pid;
                    offset_next     = req.offset;
                    data_next       = req.data_in;
                    cnt_next        = eff_cnt;
                    scan_cnt_next   = '0;
                    cmp_vld_next    = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    ok_next         = 1'b0;
                    bucket_next     = '0;
                    rdata_next      = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one owner read a cycle, compare it the next cycle
                cmp_vld_next = scan_issue;
                cmp_idx_next = scan_cnt_reg[PAGE_W-1:0];
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (page_used_reg[cmp_idx_reg] && (owner_rdata == pid_reg) && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = cmp_idx_reg;
                    end
                    if (!page_used_reg[cmp_idx_reg] && (CNT_W'(cmp_idx_reg) < cnt_reg) &&
                        !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == PAGE_W'(MAX_PAGES - 1))
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_RESP;
                unique case (req_type_reg)
                    REQ_INSERT:
                    begin
                        if (free_found_reg && !found_reg)
                        begin
                            page_used_next[free_idx_reg] = 1'b1;
                            owner_we                     = 1'b1;
                            ok_next                      = 1'b1;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        ok_next      = found_reg;
                        div_dvd_next = DIV_W'(pid_reg) << (DIV_W - PID_W);
                        div_dsr_next = R_W'(cnt_reg);
                        div_rem_next = '0;
                        div_cnt_next = STEP_W'(PID_W);
                        state_next   = ST_DIV;
                    end
                    REQ_WRITE, REQ_READ:
                    begin
                        // word address wraps at the memory size
                        if (off_ok && found_reg)
                        begin
                            addr_next  = ADDR_W'(mul_sum);
                            state_next = ST_MEM;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (found_reg)
                        begin
                            page_used_next[found_idx_reg] = 1'b0;
                            ok_next                       = 1'b1;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            ST_DIV:
            begin
                div_rem_next = div_rem_new;
                div_dvd_next = div_dvd_reg << 1;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == STEP_W'(1))
                begin
                    bucket_next = div_rem_new[BUCKET_W-1:0];
                    state_next  = ST_RESP;
                end
            end

            ST_MEM:
            begin
                if (req_type_reg == REQ_WRITE)
                begin
                    word_we    = 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_RDWAIT;
                end
            end

            ST_RDWAIT:
            begin
                rdata_next = word_rdata;
                ok_next    = 1'b1;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            page_used_reg  <= '0;
            page_len_reg   <= PSIZE_RESET;
            page_count_reg <= PCOUNT_RESET;
            clr_cnt_reg    <= '0;
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            page_used_reg  <= page_used_next;
            clr_cnt_reg    <= clr_cnt_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            div_cnt_reg    <= div_cnt_next;
            if (cfg.valid)
            begin
                if (cfg.index == CFG_PAGE_LEN)
                begin
                    page_len_reg <= cfg.data[PSIZE_W-1:0];
                end
                else if (cfg.index == CFG_PAGE_COUNT)
                begin
                    page_count_reg <= cfg.data[PCOUNT_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        pid_reg       <= pid_next;
        offset_reg    <= offset_next;
        data_reg      <= data_next;
        cnt_reg       <= cnt_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        div_rem_reg   <= div_rem_next;
        div_dvd_reg   <= div_dvd_next;
        div_dsr_reg   <= div_dsr_next;
        addr_reg      <= addr_next;
        ok_reg        <= ok_next;
        bucket_reg    <= bucket_next;
        rdata_reg     <= rdata_next;
    end

    // channel outputs
    assign cfg.ready     = 1'b1;
    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = (state_reg == ST_RESP);
    assign rsp.ok        = ok_reg;
    assign rsp.bucket    = bucket_reg;
    assign rsp.read_data = rdata_reg;

    // a request transfer always starts the owner scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN))
        else $error("request transfer did not start the scan");

    // a successful insert marks its page used
    a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && req_type_reg == REQ_INSERT && free_found_reg &&
         !found_reg) |=> page_used_reg[$past(free_idx_reg)])
        else $error("insert did not mark its page");

    // read data only comes back on a successful read
    a_rdata_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.read_data != '0) |-> (req_type_reg == REQ_READ && rsp.ok))
        else $error("read data on a request that is not a successful read");

    // bucket only comes back on a search
    a_bucket_search: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.bucket != '0) |-> (req_type_reg == REQ_SEARCH))
        else $error("bucket on a request that is not a search");

endmodule

>>> hdl/ppa_ram.sv
// generic single write port ram with registered read
module ppa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
